FILE: hdl/lut3d_pkg.sv
// Shared types, constants and helpers for the 3D LUT color grade unit.
`timescale 1ns / 1ps

package lut3d_pkg;

    localparam int MAX_GRID_DEF = 32;   // default grid points per axis
    localparam int QDEPTH       = 2;    // words between front and back

    localparam logic [16:0] ONE_Q16   = 17'h10000;
    localparam logic [7:0]  FULL_BYTE = 8'hFF;

    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_PIXEL = 1'b1;

    localparam logic [1:0] REG_TABLE_SIZE = 2'd0;
    localparam logic [1:0] REG_BLEND      = 2'd1;
    localparam logic [1:0] REG_PREMULT    = 2'd2;

    typedef logic [16:0] q16_t;

    typedef struct packed {
        q16_t red;
        q16_t green;
        q16_t blue;
    } rgb_t;

    // One queued word: a table write or a pixel with normalized color.
    typedef struct packed {
        logic        pixel;
        logic [14:0] index;
        rgb_t        val;
        logic [7:0]  alpha;
        logic [7:0]  div;
    } lut3d_word_t;

    typedef enum logic [1:0] {
        F_IDLE,
        F_DIV,
        F_PUSH
    } front_state_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_POS,
        B_BASE,
        B_READ,
        B_DRAIN,
        B_LERP,
        B_MIX,
        B_OUT
    } back_state_t;

    function automatic q16_t sat_one(logic [16:0] v);
        return (v > ONE_Q16) ? ONE_Q16 : v;
    endfunction

endpackage

FILE: hdl/lut3d_ram.sv
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps

module lut3d_ram #(
    parameter int WIDTH = 51,
    parameter int DEPTH = 32768
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: hdl/lut3d_front.sv
// Front end: saturates table entries, un-premultiplies or normalizes pixels.
`timescale 1ns / 1ps

module lut3d_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               mode,
    input  logic [14:0]        entry_index,
    input  logic [16:0]        entry_red,
    input  logic [16:0]        entry_green,
    input  logic [16:0]        entry_blue,
    input  logic [7:0]         pix_alpha,
    input  logic [7:0]         pix_red,
    input  logic [7:0]         pix_green,
    input  logic [7:0]         pix_blue,
    input  logic               premult,
    input  logic               fifo_full,
    output logic               busy,
    output logic               push,
    output lut3d_pkg::lut3d_word_t push_word
);
    import lut3d_pkg::*;

    front_state_t state_reg, state_next;
    logic [2:0]   step_reg;
    logic [7:0]   div_reg;
    logic [7:0]   alpha_reg;
    logic [15:0]  lo_sr_reg;
    logic [7:0]   rem_reg [3];
    logic [15:0]  q_reg [3];
    logic         sat_reg [3];
    logic [7:0]   pix_in [3];
    logic [7:0]   d_in;
    logic [9:0]   dstep [3];
    q16_t         u [3];

    // two restoring quotient bits per call
    function automatic logic [9:0] div_step2(logic [7:0] rem, logic [7:0] d,
                                             logic [1:0] bits);
        logic [8:0] r;
        logic       q1;
        logic       q0;
        r = {rem, bits[1]};
        q1 = (r >= {1'b0, d});
        if (q1)
        begin
            r = r - {1'b0, d};
        end
        r = {r[7:0], bits[0]};
        q0 = (r >= {1'b0, d});
        if (q0)
        begin
            r = r - {1'b0, d};
        end
        return {r[7:0], q1, q0};
    endfunction

    assign pix_in[0] = pix_red;
    assign pix_in[1] = pix_green;
    assign pix_in[2] = pix_blue;
    assign d_in = (premult && (pix_alpha != 8'd0)) ? pix_alpha : FULL_BYTE;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            dstep[i] = div_step2(rem_reg[i], div_reg, lo_sr_reg[15:14]);
            u[i] = sat_reg[i] ? ONE_Q16 : {1'b0, q_reg[i]};
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            F_IDLE:
            begin
                if (start && !busy && (mode == MODE_PIXEL))
                begin
                    state_next = F_DIV;
                end
            end
            F_DIV:
            begin
                if (step_reg == 3'd7)
                begin
                    state_next = F_PUSH;
                end
            end
            F_PUSH:
            begin
                if (!fifo_full)
                begin
                    state_next = F_IDLE;
                end
            end
            default: state_next = F_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        busy = (state_reg != F_IDLE) || fifo_full;
        push = 1'b0;
        push_word.pixel     = 1'b1;
        push_word.index     = entry_index;
        push_word.val.red   = u[0];
        push_word.val.green = u[1];
        push_word.val.blue  = u[2];
        push_word.alpha     = alpha_reg;
        push_word.div       = div_reg;
        unique case (state_reg)
            F_IDLE:
            begin
                push = start && !fifo_full && (mode == MODE_WRITE);
                push_word.pixel     = 1'b0;
                push_word.val.red   = sat_one(entry_red);
                push_word.val.green = sat_one(entry_green);
                push_word.val.blue  = sat_one(entry_blue);
            end
            F_DIV:  push = 1'b0;
            F_PUSH: push = !fifo_full;
            default: push = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            step_reg  <= 3'd0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= (state_reg == F_DIV) ? step_reg + 3'd1 : 3'd0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == F_IDLE)
        begin
            div_reg   <= d_in;
            alpha_reg <= pix_alpha;
            lo_sr_reg <= 16'(d_in - 8'd1);
            for (int i = 0; i < 3; i++)
            begin
                rem_reg[i] <= pix_in[i];
                sat_reg[i] <= (pix_in[i] >= d_in);
                q_reg[i]   <= 16'd0;
            end
        end
        else if (state_reg == F_DIV)
        begin
            lo_sr_reg <= {lo_sr_reg[13:0], 2'b00};
            for (int i = 0; i < 3; i++)
            begin
                rem_reg[i] <= dstep[i][9:2];
                q_reg[i]   <= {q_reg[i][13:0], dstep[i][1:0]};
            end
        end
    end

endmodule

FILE: hdl/lut3d_fifo.sv
// Short word queue between front and back end.
`timescale 1ns / 1ps

module lut3d_fifo (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  lut3d_pkg::lut3d_word_t push_word,
    input  logic                   pop,
    output lut3d_pkg::lut3d_word_t head,
    output logic                   empty,
    output logic                   full
);
    import lut3d_pkg::*;

    localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int CNTW = $clog2(QDEPTH + 1);

    lut3d_word_t     mem_reg [QDEPTH];
    logic [PW-1:0]   wr_ptr_reg;
    logic [PW-1:0]   rd_ptr_reg;
    logic [CNTW-1:0] count_reg;

    assign empty = (count_reg == CNTW'(0));
    assign full  = (count_reg == CNTW'(QDEPTH));
    assign head  = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_word;
        end
    end

endmodule

FILE: hdl/lut3d_back.sv
// Back end: table writes, corner reads, trilinear lerp, blend and output.
`timescale 1ns / 1ps

module lut3d_back #(
    parameter int MAX_GRID = lut3d_pkg::MAX_GRID_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [5:0]             table_size,
    input  logic [16:0]            blend_amount,
    input  lut3d_pkg::lut3d_word_t head,
    input  logic                   empty,
    output logic                   pop,
    output logic                   done,
    output logic [7:0]             out_alpha,
    output logic [7:0]             out_red,
    output logic [7:0]             out_green,
    output logic [7:0]             out_blue
);
    import lut3d_pkg::*;

    localparam int DEPTH = MAX_GRID * MAX_GRID * MAX_GRID;
    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(MAX_GRID);
    localparam int SW = $clog2(MAX_GRID + 1);
    localparam int PWD = 17 + SW;

    back_state_t state_reg, state_next;
    logic [2:0]  step_reg;
    rgb_t        orig_reg;
    logic [7:0]  alpha_reg;
    logic [7:0]  div_reg;
    logic [CW-1:0] lo_reg [3];
    logic [CW-1:0] hi_reg [3];
    logic [15:0]   w_reg [3];
    logic [AW-1:0] rlo_s_reg;
    logic [AW-1:0] rhi_s_reg;
    rgb_t          corner_reg [8];
    logic          cap_valid_reg;
    logic [2:0]    cap_k_reg;
    rgb_t          mix_reg;
    logic          done_reg;
    logic [7:0]    out_alpha_reg, out_red_reg, out_green_reg, out_blue_reg;

    logic [SW-1:0] grid;
    logic [SW-1:0] smax;
    logic [16:0]   tmix;
    q16_t          orig_ch [3];
    logic [PWD-1:0] p [3];
    logic [SW:0]    lo_c [3];
    logic [SW:0]    hi_c [3];
    logic [CW+SW-1:0] prod_lo, prod_hi;
    logic [AW-1:0]    rs_sel;
    logic [CW-1:0]    g_sel, b_sel;
    logic [AW-1:0]    row_sum;
    logic [AW+SW-1:0] row_prod;
    logic [AW-1:0]    rd_addr;
    logic             ram_we;
    logic [AW-1:0]    ram_addr;
    rgb_t             ram_rdata;
    rgb_t             a_op, b_op, lerp_res, mix_res;
    logic [15:0]      w_sel;
    logic [2:0]       dest;
    logic [24:0]      byte_r, byte_g, byte_b;

    // lo + (hi - lo) * w, rounded, weight Q0.16 up to one
    function automatic q16_t lerp_q16(q16_t lo, q16_t hi, logic [16:0] w);
        logic signed [17:0] diff;
        logic signed [35:0] acc;
        diff = $signed({1'b0, hi}) - $signed({1'b0, lo});
        acc = $signed({3'b000, lo, 16'h0000}) + diff * $signed({1'b0, w})
              + 36'sd32768;
        return acc[32:16];
    endfunction

    assign grid = (int'(table_size) > MAX_GRID) ? SW'(MAX_GRID) : SW'(table_size);
    assign smax = grid - SW'(1);
    assign tmix = sat_one(blend_amount);

    assign orig_ch[0] = orig_reg.red;
    assign orig_ch[1] = orig_reg.green;
    assign orig_ch[2] = orig_reg.blue;

    // grid position per axis: low corner, high corner, weight
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            p[i] = PWD'(orig_ch[i]) * PWD'(smax);
            lo_c[i] = (p[i][PWD-1:16] > {1'b0, smax}) ? {1'b0, smax} : p[i][PWD-1:16];
            hi_c[i] = ((lo_c[i] + 1'b1) < {1'b0, smax}) ? lo_c[i] + 1'b1 : {1'b0, smax};
        end
    end

    assign prod_lo = (CW+SW)'(lo_reg[0]) * (CW+SW)'(grid);
    assign prod_hi = (CW+SW)'(hi_reg[0]) * (CW+SW)'(grid);

    // corner k: bit 2 red, bit 1 green, bit 0 blue
    assign rs_sel   = step_reg[2] ? rhi_s_reg : rlo_s_reg;
    assign g_sel    = step_reg[1] ? hi_reg[1] : lo_reg[1];
    assign b_sel    = step_reg[0] ? hi_reg[2] : lo_reg[2];
    assign row_sum  = rs_sel + AW'(g_sel);
    assign row_prod = (AW+SW)'(row_sum) * (AW+SW)'(grid);
    assign rd_addr  = AW'(row_prod) + AW'(b_sel);

    // lerp tree in place: blue pairs, then green, then red
    always_comb
    begin
        a_op  = corner_reg[0];
        b_op  = corner_reg[1];
        w_sel = w_reg[2];
        dest  = 3'd0;
        unique case (step_reg)
            3'd0: begin a_op = corner_reg[0]; b_op = corner_reg[1]; dest = 3'd0; end
            3'd1: begin a_op = corner_reg[2]; b_op = corner_reg[3]; dest = 3'd1; end
            3'd2: begin a_op = corner_reg[4]; b_op = corner_reg[5]; dest = 3'd2; end
            3'd3: begin a_op = corner_reg[6]; b_op = corner_reg[7]; dest = 3'd3; end
            3'd4:
            begin
                a_op = corner_reg[0]; b_op = corner_reg[1];
                w_sel = w_reg[1]; dest = 3'd0;
            end
            3'd5:
            begin
                a_op = corner_reg[2]; b_op = corner_reg[3];
                w_sel = w_reg[1]; dest = 3'd1;
            end
            3'd6:
            begin
                a_op = corner_reg[0]; b_op = corner_reg[1];
                w_sel = w_reg[0]; dest = 3'd0;
            end
            default:
            begin
                a_op = corner_reg[0]; b_op = corner_reg[1];
                w_sel = w_reg[0]; dest = 3'd0;
            end
        endcase
        lerp_res.red   = sat_one(lerp_q16(a_op.red,   b_op.red,   {1'b0, w_sel}));
        lerp_res.green = sat_one(lerp_q16(a_op.green, b_op.green, {1'b0, w_sel}));
        lerp_res.blue  = sat_one(lerp_q16(a_op.blue,  b_op.blue,  {1'b0, w_sel}));
        mix_res.red    = sat_one(lerp_q16(orig_reg.red,   corner_reg[0].red,   tmix));
        mix_res.green  = sat_one(lerp_q16(orig_reg.green, corner_reg[0].green, tmix));
        mix_res.blue   = sat_one(lerp_q16(orig_reg.blue,  corner_reg[0].blue,  tmix));
    end

    assign byte_r = 25'(mix_reg.red)   * 25'(div_reg);
    assign byte_g = 25'(mix_reg.green) * 25'(div_reg);
    assign byte_b = 25'(mix_reg.blue)  * 25'(div_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE:
            begin
                if (!empty && head.pixel)
                begin
                    state_next = B_POS;
                end
            end
            B_POS:   state_next = (grid < SW'(2)) ? B_MIX : B_BASE;
            B_BASE:  state_next = B_READ;
            B_READ:  state_next = (step_reg == 3'd7) ? B_DRAIN : B_READ;
            B_DRAIN: state_next = B_LERP;
            B_LERP:  state_next = (step_reg == 3'd6) ? B_MIX : B_LERP;
            B_MIX:   state_next = B_OUT;
            B_OUT:   state_next = B_IDLE;
            default: state_next = B_IDLE;
        endcase
    end

    // table port and queue control
    always_comb
    begin
        pop      = 1'b0;
        ram_we   = 1'b0;
        ram_addr = rd_addr;
        unique case (state_reg)
            B_IDLE:
            begin
                pop      = !empty;
                ram_we   = !empty && !head.pixel && (int'(head.index) < DEPTH);
                ram_addr = AW'(head.index);
            end
            B_POS, B_BASE, B_READ, B_DRAIN, B_LERP, B_MIX, B_OUT:
            begin
                pop      = 1'b0;
                ram_we   = 1'b0;
                ram_addr = rd_addr;
            end
            default:
            begin
                pop      = 1'b0;
                ram_we   = 1'b0;
                ram_addr = rd_addr;
            end
        endcase
    end

    lut3d_ram #(
        .WIDTH ($bits(rgb_t)),
        .DEPTH (DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (head.val),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            step_reg      <= 3'd0;
            cap_valid_reg <= 1'b0;
            cap_k_reg     <= 3'd0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= (state_next == state_reg) ? step_reg + 3'd1 : 3'd0;
            cap_valid_reg <= (state_reg == B_READ);
            cap_k_reg     <= step_reg;
            done_reg      <= (state_reg == B_OUT);
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == B_IDLE) && !empty && head.pixel)
        begin
            orig_reg      <= head.val;
            corner_reg[0] <= head.val;
            alpha_reg     <= head.alpha;
            div_reg       <= head.div;
        end
        if (state_reg == B_POS)
        begin
            for (int i = 0; i < 3; i++)
            begin
                lo_reg[i] <= CW'(lo_c[i]);
                hi_reg[i] <= CW'(hi_c[i]);
                w_reg[i]  <= p[i][15:0];
            end
        end
        if (state_reg == B_BASE)
        begin
            rlo_s_reg <= AW'(prod_lo);
            rhi_s_reg <= AW'(prod_hi);
        end
        if (cap_valid_reg)
        begin
            corner_reg[cap_k_reg] <= ram_rdata;
        end
        if (state_reg == B_LERP)
        begin
            corner_reg[dest] <= lerp_res;
        end
        if (state_reg == B_MIX)
        begin
            mix_reg <= mix_res;
        end
        if (state_reg == B_OUT)
        begin
            out_alpha_reg <= alpha_reg;
            out_red_reg   <= byte_r[23:16];
            out_green_reg <= byte_g[23:16];
            out_blue_reg  <= byte_b[23:16];
        end
    end

    assign done      = done_reg;
    assign out_alpha = out_alpha_reg;
    assign out_red   = out_red_reg;
    assign out_green = out_green_reg;
    assign out_blue  = out_blue_reg;

endmodule

FILE: hdl/lut3d_trilinear_color_grade_unit.sv
// Top level of the 3D LUT trilinear color grade unit.
`timescale 1ns / 1ps

// Pixel throughput is set by the back end, which pops the next word only after
//   it has finished a pixel (eight corner reads from the single-port table,
//   seven lerp steps, blend and byte stages); table writes retire one per cycle
//   while the back end holds no pixel.
// done is a one-cycle strobe; the receiver cannot stall it.
// Reset (rst_n, async, low) clears control and config; table stays unknown.
module lut3d_trilinear_color_grade_unit #(
    parameter int MAX_GRID = lut3d_pkg::MAX_GRID_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration write port
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [16:0] cfg_data,
    // input word
    input  logic        start,
    output logic        busy,
    input  logic        mode,
    input  logic [14:0] entry_index,
    input  logic [16:0] entry_red,
    input  logic [16:0] entry_green,
    input  logic [16:0] entry_blue,
    input  logic [7:0]  pix_alpha,
    input  logic [7:0]  pix_red,
    input  logic [7:0]  pix_green,
    input  logic [7:0]  pix_blue,
    // result word
    output logic        done,
    output logic [7:0]  out_alpha,
    output logic [7:0]  out_red,
    output logic [7:0]  out_green,
    output logic [7:0]  out_blue
);
    import lut3d_pkg::*;

    logic [5:0]  table_size_reg;
    logic [16:0] blend_reg;
    logic        premult_reg;

    lut3d_word_t push_word;
    lut3d_word_t head;
    logic        push;
    logic        pop;
    logic        fifo_empty;
    logic        fifo_full;

    // Config registers. The user must write them only while the unit is idle;
    // the block itself has no check for this, and the datapath reads them directly.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            table_size_reg <= 6'd0;
            blend_reg      <= 17'd0;
            premult_reg    <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_TABLE_SIZE: table_size_reg <= cfg_data[5:0];
                REG_BLEND:      blend_reg      <= cfg_data;
                REG_PREMULT:    premult_reg    <= cfg_data[0];
                default:        ;
            endcase
        end
    end

    // Front end: table words go straight to the queue with entries clipped
    // to one; pixels get their colors normalized to Q0.16 by a two-bit-per-
    // cycle divide (by nonzero alpha when premultiplied, else by 255).
    lut3d_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .mode        (mode),
        .entry_index (entry_index),
        .entry_red   (entry_red),
        .entry_green (entry_green),
        .entry_blue  (entry_blue),
        .pix_alpha   (pix_alpha),
        .pix_red     (pix_red),
        .pix_green   (pix_green),
        .pix_blue    (pix_blue),
        .premult     (premult_reg),
        .fifo_full   (fifo_full),
        .busy        (busy),
        .push        (push),
        .push_word   (push_word)
    );

    // Queue keeps word order so table writes and lookups stay in sequence.
    lut3d_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_word (push_word),
        .pop       (pop),
        .head      (head),
        .empty     (fifo_empty),
        .full      (fifo_full)
    );

    // Back end: owns the table memory; does writes, the eight-corner
    // lookup, trilinear lerp, blend and re-premultiply to bytes.
    lut3d_back #(
        .MAX_GRID (MAX_GRID)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .table_size   (table_size_reg),
        .blend_amount (blend_reg),
        .head         (head),
        .empty        (fifo_empty),
        .pop          (pop),
        .done         (done),
        .out_alpha    (out_alpha),
        .out_red      (out_red),
        .out_green    (out_green),
        .out_blue     (out_blue)
    );

endmodule
